/* hw/rtl/base58_string_decoder_top_macros.svh */
// Assertion macros used by the base58 decoder checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef BASE58_STRING_DECODER_TOP_MACROS_SVH
`define BASE58_STRING_DECODER_TOP_MACROS_SVH

// Clocked check, switched off while reset is high.
`define B58D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define B58D_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/b58d_pkg.sv */
// Shared types, constants and character classification for the base58 decoder.
// No dependencies.
package b58d_pkg;

  localparam int MAX_CHARS_DEF = 128;
  localparam int BUF_BYTES_DEF = 94;
  localparam int OUT_BYTES     = 128;
  localparam int RADIX         = 58;
  localparam int DIGIT_W       = 6;
  localparam int WORD_W        = 32;
  localparam int Q_DEPTH       = 4;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ONE = 8'h31;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_CHAR,
    ST_GARBAGE,
    ST_TOO_LONG
  } b58d_status_t;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_ONES,
    PH_DIGITS,
    PH_TRAIL
  } b58d_phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_FIN,
    BK_SCAN,
    BK_CHECK,
    BK_EMIT,
    BK_PUSH
  } b58d_bstate_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] value;
  } b58d_digit_t;

  // One command from the front end to the arithmetic back end.
  typedef struct packed {
    logic               has_digit;
    logic               is_final;
    b58d_status_t       err;
    logic [DIGIT_W-1:0] digit;
  } b58d_cmd_t;

  function automatic logic b58d_is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Alphabet 1-9 A-H J-N P-Z a-k m-z (no 0, I, O, l).
  function automatic b58d_digit_t b58d_lookup(input logic [7:0] c);
    b58d_digit_t d;
    d.valid = 1'b1;
    d.value = '0;
    if (c >= "1" && c <= "9") begin
      d.value = DIGIT_W'(c - "1");
    end else if (c >= "A" && c <= "H") begin
      d.value = DIGIT_W'(c - "A" + 8'd9);
    end else if (c >= "J" && c <= "N") begin
      d.value = DIGIT_W'(c - "J" + 8'd17);
    end else if (c >= "P" && c <= "Z") begin
      d.value = DIGIT_W'(c - "P" + 8'd22);
    end else if (c >= "a" && c <= "k") begin
      d.value = DIGIT_W'(c - "a" + 8'd33);
    end else if (c >= "m" && c <= "z") begin
      d.value = DIGIT_W'(c - "m" + 8'd44);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

/* hw/rtl/b58d_in_if.sv */
// Character input channel of the base58 decoder: valid/ready plus one text byte.
// No dependencies.
interface b58d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_final;

  modport source (output valid, char_code, is_final, input ready);
  modport sink (input valid, char_code, is_final, output ready);
endinterface

/* hw/rtl/b58d_out_if.sv */
// Result channel of the base58 decoder: valid/ready plus one packed result word.
// No dependencies.
interface b58d_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        end_flag;
  logic [1:0]  status;

  modport source (output valid, data_word, byte_count, end_flag, status, input ready);
  modport sink (input valid, data_word, byte_count, end_flag, status, output ready);
endinterface

/* hw/rtl/b58d_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module b58d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/b58d_queue.sv */
// Short command queue between the decoder front end and back end.
// No dependencies.
module b58d_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/b58d_front.sv */
// Decoder front end: takes characters, tracks the parse phase, counts leading ones
// and queues digit and end-of-string commands. Uses b58d_pkg and b58d_in_if.
module b58d_front
  import b58d_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  localparam int ZW = $clog2(MAX_CHARS + 1),
  localparam int CW = $clog2(MAX_CHARS + 2)
) (
  input  logic            clk,
  input  logic            rst,
  b58d_in_if.sink         chars,
  input  logic            full,
  output logic            push,
  output b58d_cmd_t       cmd,
  output logic [ZW-1:0]   zeros
);

  b58d_phase_t  phase, phase_next;
  logic [ZW-1:0] zcnt, zcnt_next;
  logic [CW-1:0] ccnt, ccnt_next;
  logic          nul_seen, nul_seen_next;
  b58d_status_t  err, err_next;

  logic          accept;
  logic          sp;
  logic          is_one;
  logic          want_digit;
  logic          take_digit;
  b58d_digit_t   dig;

  assign chars.ready = !full;
  assign accept      = chars.valid && chars.ready;
  assign sp          = b58d_is_space(chars.char_code);
  assign is_one      = (chars.char_code == CH_ONE);
  assign dig         = b58d_lookup(chars.char_code);

  // Parse state after this character, before the end-of-string clear.
  always_comb begin
    phase_next    = phase;
    zcnt_next     = zcnt;
    ccnt_next     = ccnt;
    nul_seen_next = nul_seen;
    err_next      = err;
    want_digit    = 1'b0;
    take_digit    = 1'b0;
    if (accept && !nul_seen && err == ST_OK) begin
      if (chars.char_code == CH_NUL) begin
        nul_seen_next = 1'b1;
      end else begin
        ccnt_next = ccnt + CW'(1);
        if (32'(ccnt_next) > MAX_CHARS) begin
          err_next = ST_TOO_LONG;
        end else begin
          unique case (phase)
            PH_LEAD: begin
              if (!sp) begin
                if (is_one) begin
                  phase_next = PH_ONES;
                  zcnt_next  = zcnt + ZW'(1);
                end else begin
                  phase_next = PH_DIGITS;
                  want_digit = 1'b1;
                end
              end
            end
            PH_ONES: begin
              if (is_one) begin
                zcnt_next = zcnt + ZW'(1);
              end else if (sp) begin
                phase_next = PH_TRAIL;
              end else begin
                phase_next = PH_DIGITS;
                want_digit = 1'b1;
              end
            end
            PH_DIGITS: begin
              if (sp) begin
                phase_next = PH_TRAIL;
              end else begin
                want_digit = 1'b1;
              end
            end
            PH_TRAIL: begin
              if (!sp) begin
                err_next = ST_GARBAGE;
              end
            end
            default: begin
              phase_next = PH_LEAD;
            end
          endcase
          if (want_digit) begin
            if (dig.valid) begin
              take_digit = 1'b1;
            end else begin
              err_next = ST_BAD_CHAR;
            end
          end
        end
      end
    end
  end

  // Queue outputs: the final command carries the error and the zero-byte count.
  always_comb begin
    push          = accept && (take_digit || chars.is_final);
    cmd.has_digit = take_digit;
    cmd.is_final  = chars.is_final;
    cmd.err       = err_next;
    cmd.digit     = dig.value;
    zeros         = zcnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && chars.is_final)) begin
      phase    <= PH_LEAD;
      zcnt     <= '0;
      ccnt     <= '0;
      nul_seen <= 1'b0;
      err      <= ST_OK;
    end else begin
      phase    <= phase_next;
      zcnt     <= zcnt_next;
      ccnt     <= ccnt_next;
      nul_seen <= nul_seen_next;
      err      <= err_next;
    end
  end

endmodule

/* hw/rtl/b58d_back.sv */
// Decoder back end: runs the multiply-by-58 pass over the word buffer, finds the
// significant bytes and packs results. Uses b58d_pkg, b58d_out_if and b58d_ram.
module b58d_back
  import b58d_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int BUF_BYTES = BUF_BYTES_DEF,
  localparam int ZW = $clog2(MAX_CHARS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  b58d_cmd_t     cmd,
  input  logic [ZW-1:0] zeros,
  input  logic          empty,
  output logic          pop,
  b58d_out_if.source    results
);

  localparam int NW        = (BUF_BYTES + 3) / 4;
  localparam int AW        = $clog2(NW);
  localparam int UW        = $clog2(NW + 1);
  localparam int SW        = $clog2(BUF_BYTES + 1);
  localparam int TW        = $clog2(MAX_CHARS + BUF_BYTES + 1);
  localparam int PROD_W    = WORD_W + DIGIT_W;
  localparam int EXB       = NW * 4 - BUF_BYTES;
  localparam int KEEP_BITS = WORD_W - 8 * EXB;
  localparam logic [WORD_W-1:0] TOP_MASK = WORD_W'(~((64'd1 << KEEP_BITS) - 64'd1));

  b58d_bstate_t state, state_next;

  logic [AW-1:0]      idx;
  logic [AW-1:0]      mul_last;
  logic [UW-1:0]      uw;
  logic [DIGIT_W-1:0] carry;
  b58d_status_t       back_err;
  logic               fin_pend;
  b58d_status_t       f_err;
  logic [ZW-1:0]      f_zeros;
  logic [SW-1:0]      sig;
  logic [TW-1:0]      total;
  logic [TW-1:0]      kcnt;
  logic [SW-1:0]      pos;
  logic               rd_ok;
  logic [7:0]         asm_bytes [8];
  logic [3:0]         asm_cnt;
  logic               push_last;
  b58d_status_t       res_status;

  logic               out_valid;
  logic [63:0]        out_word;
  logic [3:0]         out_cnt;
  logic               out_end;
  b58d_status_t       out_status;

  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  rdata;

  logic [WORD_W-1:0]  word_in;
  logic [PROD_W-1:0]  prod;
  logic               mul_done;
  logic               ovf;
  logic               scan_hit;
  logic [2:0]         nb;
  logic [SW-1:0]      sig_scan;
  logic [TW-1:0]      total_c;
  b58d_status_t       err_sel;
  b58d_status_t       err_fin;
  logic               scan_go;
  logic               start_mul;
  logic               in_zeros;
  logic               need_read;
  logic [7:0]         emit_byte;
  logic               k_last;
  logic               out_free;

  b58d_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NW)
  ) u_b58d_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (prod[WORD_W-1:0]),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // Words at or above uw are stale from an earlier string and read as zero.
  assign word_in  = (UW'(idx) < uw) ? rdata : '0;
  assign prod     = PROD_W'(word_in) * PROD_W'(RADIX) + PROD_W'(carry);
  assign mul_done = (idx == mul_last);
  assign ovf      = (idx == AW'(NW - 1)) &&
                    ((prod[PROD_W-1:WORD_W] != '0) || ((prod[WORD_W-1:0] & TOP_MASK) != '0));

  assign scan_hit = (rdata != '0);
  always_comb begin
    priority if (rdata[31:24] != 8'd0) nb = 3'd4;
    else if (rdata[23:16] != 8'd0)     nb = 3'd3;
    else if (rdata[15:8] != 8'd0)      nb = 3'd2;
    else                               nb = 3'd1;
  end
  assign sig_scan = SW'((AW + 3)'({idx, 2'b00}) + (AW + 3)'(nb));

  assign total_c  = TW'(f_zeros) + TW'(sig);
  assign err_sel  = (back_err != ST_OK) ? back_err : f_err;
  assign err_fin  = (err_sel == ST_OK && 32'(total_c) > OUT_BYTES) ? ST_TOO_LONG : err_sel;
  assign scan_go  = (err_sel == ST_OK) && (uw != '0);
  assign start_mul = !empty && cmd.has_digit && (back_err == ST_OK);

  assign in_zeros  = (kcnt < TW'(f_zeros));
  assign need_read = !in_zeros && !rd_ok;
  assign emit_byte = in_zeros ? 8'd0 : rdata[{pos[1:0], 3'b000} +: 8];
  assign k_last    = ((kcnt + TW'(1)) == total);
  assign out_free  = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (start_mul) begin
          state_next = BK_MUL;
        end else if (!empty && cmd.is_final) begin
          state_next = BK_FIN;
        end
      end
      BK_MUL: begin
        if (mul_done) begin
          state_next = fin_pend ? BK_FIN : BK_IDLE;
        end
      end
      BK_FIN: begin
        state_next = scan_go ? BK_SCAN : BK_CHECK;
      end
      BK_SCAN: begin
        if (scan_hit || idx == '0) begin
          state_next = BK_CHECK;
        end
      end
      BK_CHECK: begin
        state_next = (err_fin != ST_OK || total_c == '0) ? BK_PUSH : BK_EMIT;
      end
      BK_EMIT: begin
        if (!need_read && (asm_cnt == 4'd7 || k_last)) begin
          state_next = BK_PUSH;
        end
      end
      BK_PUSH: begin
        if (out_free) begin
          state_next = push_last ? BK_IDLE : BK_EMIT;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Buffer memory and queue controls.
  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      BK_IDLE: begin
        pop    = !empty;
        ram_re = start_mul;
      end
      BK_MUL: begin
        ram_we = 1'b1;
        if (!mul_done) begin
          ram_re    = 1'b1;
          ram_raddr = idx + AW'(1);
        end
      end
      BK_FIN: begin
        ram_re    = scan_go;
        ram_raddr = AW'(uw - UW'(1));
      end
      BK_SCAN: begin
        if (!scan_hit && idx != '0) begin
          ram_re    = 1'b1;
          ram_raddr = idx - AW'(1);
        end
      end
      BK_EMIT: begin
        ram_re    = need_read;
        ram_raddr = AW'(pos >> 2);
      end
      BK_CHECK, BK_PUSH: begin
        ram_re = 1'b0;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      uw        <= '0;
      back_err  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_MUL && mul_done) begin
        if (ovf) begin
          back_err <= ST_TOO_LONG;
        end else if (UW'(idx) == uw && prod[WORD_W-1:0] != '0) begin
          uw <= uw + UW'(1);
        end
      end
      if (state == BK_PUSH && out_free) begin
        out_valid <= 1'b1;
        if (push_last) begin
          uw       <= '0;
          back_err <= ST_OK;
        end
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          fin_pend <= cmd.is_final;
          f_err    <= cmd.err;
          f_zeros  <= zeros;
          carry    <= cmd.digit;
          idx      <= '0;
          mul_last <= (uw < UW'(NW)) ? AW'(uw) : AW'(NW - 1);
        end
      end
      BK_MUL: begin
        carry <= prod[PROD_W-1:WORD_W];
        if (!mul_done) begin
          idx <= idx + AW'(1);
        end
      end
      BK_FIN: begin
        sig <= '0;
        idx <= AW'(uw - UW'(1));
      end
      BK_SCAN: begin
        if (scan_hit) begin
          sig <= sig_scan;
        end else if (idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      BK_CHECK: begin
        total      <= total_c;
        res_status <= err_fin;
        kcnt       <= '0;
        pos        <= sig - SW'(1);
        rd_ok      <= 1'b0;
        asm_cnt    <= '0;
        push_last  <= (err_fin != ST_OK) || (total_c == '0);
        for (int i = 0; i < 8; i++) begin
          asm_bytes[i] <= 8'd0;
        end
      end
      BK_EMIT: begin
        if (need_read) begin
          rd_ok <= 1'b1;
        end else begin
          asm_bytes[asm_cnt[2:0]] <= emit_byte;
          asm_cnt   <= asm_cnt + 4'd1;
          kcnt      <= kcnt + TW'(1);
          push_last <= k_last;
          if (!in_zeros) begin
            pos <= pos - SW'(1);
            if (pos[1:0] == 2'd0) begin
              rd_ok <= 1'b0;
            end
          end
        end
      end
      BK_PUSH: begin
        if (out_free) begin
          out_word   <= {asm_bytes[0], asm_bytes[1], asm_bytes[2], asm_bytes[3],
                         asm_bytes[4], asm_bytes[5], asm_bytes[6], asm_bytes[7]};
          out_cnt    <= asm_cnt;
          out_end    <= push_last;
          out_status <= res_status;
          asm_cnt    <= '0;
          for (int i = 0; i < 8; i++) begin
            asm_bytes[i] <= 8'd0;
          end
        end
      end
      default: begin
        rd_ok <= 1'b0;
      end
    endcase
  end

  assign results.valid      = out_valid;
  assign results.data_word  = out_word;
  assign results.byte_count = out_cnt;
  assign results.end_flag   = out_end;
  assign results.status     = out_status;

endmodule

/* hw/rtl/base58_string_decoder_top.sv */
// Base58 string decoder, one character per transaction in, packed byte results out.
// Uses b58d_pkg, b58d_in_if, b58d_out_if, b58d_front, b58d_queue and b58d_back.
//
// The front end takes one character per cycle while the four-entry command queue is
// not full: whitespace, NUL, leading ones and characters after an error never stall
// unless that queue is full, and characters keep coming in while the back end works.
// For each digit the multiply-by-58 pass moves through the W 32-bit buffer words in
// use plus one, capped at NW = ceil(BUF_BYTES/4) words with the default 94-byte buffer,
// one word per cycle on its single read and write port. The final character adds a
// scan for the top nonzero word, then packs the output bytes into 8-byte results. The
// buffer needs no clearing pass; words above the used length read as zero.
module base58_string_decoder_top
  import b58d_pkg::*;
#(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  b58d_in_if.sink    chars,
  b58d_out_if.source results
);

  localparam int ZW = $clog2(MAX_CHARS + 1);
  localparam int QW = $bits(b58d_cmd_t) + ZW;

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  b58d_cmd_t     f_cmd;
  logic [ZW-1:0] f_zeros;
  logic [QW-1:0] q_rdata;
  b58d_cmd_t     b_cmd;
  logic [ZW-1:0] b_zeros;

  b58d_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_b58d_front (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .full  (q_full),
    .push  (q_push),
    .cmd   (f_cmd),
    .zeros (f_zeros)
  );

  b58d_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_b58d_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_cmd, f_zeros}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_cmd   = b58d_cmd_t'(q_rdata[QW-1:ZW]);
  assign b_zeros = q_rdata[ZW-1:0];

  b58d_back #(
    .MAX_CHARS (MAX_CHARS),
    .BUF_BYTES (BUF_BYTES)
  ) u_b58d_back (
    .clk     (clk),
    .rst     (rst),
    .cmd     (b_cmd),
    .zeros   (b_zeros),
    .empty   (q_empty),
    .pop     (q_pop),
    .results (results)
  );

endmodule

/* hw/rtl/b58d_checker.sv */
// Port-level checks on the decoder result channel, bound to the top level.
// Uses b58d_pkg and the macros in base58_string_decoder_top_macros.svh.
`include "base58_string_decoder_top_macros.svh"

module b58d_checker
  import b58d_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [63:0] res_word,
  input logic [3:0]  res_count,
  input logic        res_end,
  input logic [1:0]  res_status
);

  `B58D_ASSERT_RST(a_reset_idle, rst |=> !res_valid, "result valid right after reset")
  `B58D_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable(res_word) && $stable(res_count), "stalled result changed")
  `B58D_ASSERT(a_err_shape, res_valid && res_status != ST_OK |-> res_end && res_count == 4'd0 && res_word == 64'd0, "error result not a lone empty end")
  `B58D_ASSERT(a_full_word, res_valid && !res_end |-> res_count == 4'd8 && res_status == ST_OK, "non-final result not a full word")
  `B58D_ASSERT(a_count, res_valid |-> res_count <= 4'd8 && (res_count != 4'd0 || res_end), "bad byte count")

endmodule

bind base58_string_decoder_top b58d_checker u_b58d_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .res_word   (results.data_word),
  .res_count  (results.byte_count),
  .res_end    (results.end_flag),
  .res_status (results.status)
);

/* tb/sv/base58_string_decoder_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for base58_string_decoder_top: directed and random strings.
// Depends on b58d_pkg, b58d_in_if, b58d_out_if and the decoder RTL.
module base58_string_decoder_top_tb;
  import b58d_pkg::*;

  typedef struct packed {
    logic [63:0]  data;
    logic [3:0]   nbytes;
    logic         is_end;
    b58d_status_t st;
  } b58_result_t;

  logic clk;
  logic rst;

  b58d_in_if  chars_if ();
  b58d_out_if results_if ();

  base58_string_decoder_top u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  string digit_set = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // predictor state, one decode in flight at a time
  logic [7:0]   num_buf [BUF_BYTES_DEF];
  int unsigned  used_len;
  int unsigned  zero_lead;
  int unsigned  char_cnt;
  b58d_phase_t  phase;
  b58d_status_t err_st;
  bit           nul_seen;

  b58_result_t  pending_words[$];
  b58_result_t  want;
  int           error_cnt = 0;
  int           words_checked = 0;
  int           strings_sent;
  int           chars_sent;
  int           random_chars;
  bit           steady;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    for (int k = 0; k < RADIX; k++) begin
      if (digit_set[k] == c) return k;
    end
    return RADIX;
  endfunction

  function automatic void clear_decode();
    foreach (num_buf[i]) num_buf[i] = 8'h00;
    used_len  = 0;
    zero_lead = 0;
    char_cnt  = 0;
    phase     = PH_LEAD;
    err_st    = ST_OK;
    nul_seen  = 1'b0;
  endfunction

  // number = number * 58 + digit, big-endian bytes
  function automatic void mul_add(input logic [7:0] c);
    int unsigned carry;
    int unsigned i;
    int unsigned pos;
    carry = digit_value(c);
    i = 0;
    if (carry >= RADIX) begin
      err_st = ST_BAD_CHAR;
      return;
    end
    while ((carry != 0 || i < used_len) && i < BUF_BYTES_DEF) begin
      pos = BUF_BYTES_DEF - 1 - i;
      carry += RADIX * num_buf[pos];
      num_buf[pos] = carry[7:0];
      carry >>= 8;
      i++;
    end
    if (carry != 0) err_st = ST_TOO_LONG;
    else used_len = i;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    bit sp;
    sp = is_ws(c);
    case (phase)
      PH_LEAD: begin
        if (sp) return;
        if (c == CH_ONE) begin
          phase = PH_ONES;
          zero_lead++;
        end else begin
          phase = PH_DIGITS;
          mul_add(c);
        end
      end
      PH_ONES: begin
        if (c == CH_ONE) zero_lead++;
        else if (sp) phase = PH_TRAIL;
        else begin
          phase = PH_DIGITS;
          mul_add(c);
        end
      end
      PH_DIGITS: begin
        if (sp) phase = PH_TRAIL;
        else mul_add(c);
      end
      default: begin
        if (!sp) err_st = ST_GARBAGE;
      end
    endcase
  endfunction

  function automatic void emit_decoded();
    int unsigned first;
    int unsigned total;
    int unsigned nwords;
    int unsigned idx;
    int unsigned pos;
    logic [7:0]  value;
    b58_result_t r;
    first = BUF_BYTES_DEF - ((used_len <= BUF_BYTES_DEF) ? used_len : BUF_BYTES_DEF);
    while (first < BUF_BYTES_DEF && num_buf[first] == 8'h00) first++;
    total = zero_lead + (BUF_BYTES_DEF - first);
    if (err_st == ST_OK && total > OUT_BYTES) err_st = ST_TOO_LONG;
    if (err_st != ST_OK) begin
      r = '0;
      r.is_end = 1'b1;
      r.st = err_st;
      pending_words = {pending_words, r};
    end else begin
      nwords = (total == 0) ? 1 : (total + 7) / 8;
      for (int k = 0; k < nwords; k++) begin
        r = '0;
        r.st = ST_OK;
        for (int b = 0; b < 8; b++) begin
          idx = k * 8 + b;
          if (idx < total) begin
            value = 8'h00;
            if (idx >= zero_lead) begin
              pos = first + (idx - zero_lead);
              if (pos < BUF_BYTES_DEF) value = num_buf[pos];
            end
            r.data[63 - 8 * b -: 8] = value;
            r.nbytes++;
          end
        end
        r.is_end = (k + 1 == nwords);
        pending_words = {pending_words, r};
      end
    end
    clear_decode();
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic fin);
    if (!nul_seen && err_st == ST_OK) begin
      if (c == CH_NUL) nul_seen = 1'b1;
      else begin
        char_cnt++;
        if (char_cnt > MAX_CHARS_DEF) err_st = ST_TOO_LONG;
        else parse_char(c);
      end
    end
    if (fin) emit_decoded();
  endfunction

  // one character transaction; valid stays high into the next call unless a gap is drawn
  task automatic push_char(input logic [7:0] c, input logic fin);
    while (!steady && $urandom_range(99) < 19) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.is_final  <= fin;
    do @(posedge clk); while (!chars_if.ready);
    decode_char(c, fin);
    chars_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) push_char(q[i], i == q.size() - 1);
  endtask

  // hold the input until every outstanding result has come back
  task automatic drain();
    chars_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_ws();
    int unsigned w;
    w = $urandom_range(5);
    return (w == 5) ? 8'd32 : 8'(9 + w);
  endfunction

  function automatic logic [7:0] pick_digit();
    return digit_set[$urandom_range(RADIX - 1)];
  endfunction

  function automatic logic [7:0] pick_bad();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_ws(c) || digit_value(c) < RADIX);
    return c;
  endfunction

  task automatic test_empty_strings();
    push_char(CH_NUL, 1'b1);
    send_text(" ");
    send_text("1");
    send_text("2");
    send_text("z");
  endtask

  task automatic test_whitespace_and_ones();
    send_text("\011\012 113yQ\015\013\014 ");
    send_text("111 ");
    send_text("11zz");
  endtask

  task automatic test_bad_chars();
    send_text("0");
    send_text("3I");
    send_text("O");
    send_text("4l");
    push_char(8'hFF, 1'b1);
    send_text("5\200");
    send_text("0abc 7");
  endtask

  task automatic test_garbage();
    send_text("2 3");
    send_text("11 1");
    send_text(" 5 x");
  endtask

  task automatic test_nul_terminator();
    send_text("3y");
    push_char(CH_NUL, 1'b0);
    send_text("0! I");
    push_char(CH_ONE, 1'b0);
    push_char(CH_ONE, 1'b0);
    push_char(CH_NUL, 1'b1);
  endtask

  // no idling on either side through these long strings
  task automatic test_length_limits();
    logic [7:0] q[$];
    steady = 1'b1;
    // at the character cap, and 128 output bytes in 16 results
    q = {};
    repeat (127) q = {q, CH_ONE};
    q = {q, "z"};
    send_bytes(q);
    // one character over the cap
    q = {};
    repeat (128) q = {q, CH_ONE};
    q = {q, "2"};
    send_bytes(q);
    steady = 1'b0;
  endtask

  task automatic test_random_strings();
    logic [7:0]  q[$];
    int unsigned kind;
    int unsigned n;
    bit          paused;
    paused = 1'b0;
    while (random_chars < 40) begin
      q = {};
      kind = $urandom_range(99);
      if (kind < 85) begin
        n = $urandom_range(2);
        repeat (n) q = {q, pick_ws()};
        if ($urandom_range(1)) begin
          n = $urandom_range(1, 3);
          repeat (n) q = {q, CH_ONE};
        end
        n = $urandom_range(12);
        repeat (n) q = {q, pick_digit()};
        n = $urandom_range(2);
        repeat (n) q = {q, pick_ws()};
        if ($urandom_range(99) < 15) begin
          q = {q, CH_NUL};
          n = $urandom_range(2);
          repeat (n) q = {q, 8'($urandom_range(255))};
        end
        if (kind >= 70 && q.size() != 0) begin
          if ($urandom_range(1)) q[$urandom_range(q.size() - 1)] = pick_bad();
          else begin
            q = {q, 8'd32};
            q = {q, pick_digit()};
          end
        end
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) q = {q, 8'($urandom_range(255))};
      end
      if (q.size() == 0) q = {q, CH_NUL};
      send_bytes(q);
      random_chars += q.size();
      if (!paused && random_chars >= 20) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  // result side: random back-pressure, compare against the oldest expectation
  always @(posedge clk) begin
    results_if.ready <= steady || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result data=%h count=%0d end=%b status=%0d", $time,
                 results_if.data_word, results_if.byte_count, results_if.end_flag,
                 results_if.status);
        error_cnt++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (results_if.data_word !== want.data) begin
          $display("%0t: data_word expected %h actual %h", $time, want.data,
                   results_if.data_word);
          error_cnt++;
        end
        if (results_if.byte_count !== want.nbytes) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, want.nbytes,
                   results_if.byte_count);
          error_cnt++;
        end
        if (results_if.end_flag !== want.is_end) begin
          $display("%0t: end_flag expected %b actual %b", $time, want.is_end,
                   results_if.end_flag);
          error_cnt++;
        end
        if (results_if.status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st,
                   results_if.status);
          error_cnt++;
        end
      end
    end
  end

  initial begin
    strings_sent  = 0;
    chars_sent    = 0;
    random_chars  = 0;
    steady        = 1'b0;
    clear_decode();
    rst                <= 1'b1;
    chars_if.valid     <= 1'b0;
    chars_if.char_code <= 8'h00;
    chars_if.is_final  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_strings();
    test_whitespace_and_ones();
    test_bad_chars();
    test_garbage();
    test_nul_terminator();
    drain();
    test_length_limits();
    test_random_strings();

    drain();
    repeat (60) @(posedge clk);
    if (pending_words.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_words.size());
    end
    $display("Decoded %0d strings from %0d characters (%0d random), %0d result words checked",
             strings_sent, chars_sent, random_chars, words_checked);
    $display("Covered whitespace, leading ones, NUL, bad chars, trailing garbage, length cap");
    if (error_cnt == 0 && pending_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/b58d_pkg.sv
hw/rtl/b58d_in_if.sv
hw/rtl/b58d_out_if.sv
hw/rtl/b58d_ram.sv
hw/rtl/b58d_queue.sv
hw/rtl/b58d_front.sv
hw/rtl/b58d_back.sv
hw/rtl/base58_string_decoder_top.sv
hw/rtl/b58d_checker.sv
tb/sv/base58_string_decoder_top_tb.sv
